// ===== rtl/cfad_pkg.sv =====
package cfad_pkg;

	// fixed field widths
	localparam int ID_BITS         = 11;
	localparam int LEN_W           = 4;
	localparam int BYTE_W          = 8;
	localparam int RPM_W           = 16;
	localparam int COUNT_W         = 8;
	localparam int TOTAL_W         = 16;
	localparam int KNOWN_COUNT     = 5;
	localparam int KNOWN_W         = KNOWN_COUNT * ID_BITS;
	localparam int EXP_W           = 3 * LEN_W;
	localparam int MAX_LENGTH_CODE = 8;
	localparam int TRACKED_SLOTS_DEF = 8;

	// configuration port
	localparam int CFG_DATA_W  = KNOWN_W;
	localparam int CFG_INDEX_W = 3;

	localparam logic [CFG_INDEX_W-1:0] REG_KNOWN_IDS        = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_LENGTHS = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_RPM_LOW          = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RPM_HIGH         = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_TEMPERATURE_HIGH = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_FUEL_HIGH        = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_FLOOD_LIMIT      = 3'd6;

	// register reset values
	localparam logic [RPM_W-1:0]   RPM_HIGH_RST    = 16'hFFFF;
	localparam logic [BYTE_W-1:0]  TEMP_HIGH_RST   = 8'hFF;
	localparam logic [BYTE_W-1:0]  FUEL_HIGH_RST   = 8'hFF;
	localparam logic [COUNT_W-1:0] FLOOD_LIMIT_RST = 8'd5;

	// verdict codes
	typedef logic [2:0] verdict_t;
	localparam verdict_t V_OK      = 3'd0;
	localparam verdict_t V_LENGTH  = 3'd1;
	localparam verdict_t V_UNKNOWN = 3'd2;
	localparam verdict_t V_RANGE   = 3'd3;
	localparam verdict_t V_FLOOD   = 3'd4;

	// slot table lookup status
	typedef struct packed {
		logic found;     // id already has a slot
		logic has_free;  // an unused slot is left
		logic fresh;     // count of the selected slot is current since last tick
	} slot_look_t;

endpackage

// ===== rtl/can_frame_anomaly_detector.sv =====
// CAN frame anomaly detector.
// Input channel (in_valid / in_stall) takes one transaction per frame or tick:
// func 0 checks a frame (can_id, length_code, data_byte0/1), func 1 clears
// all per-id frame counts. Each transaction yields exactly one result on the
// output channel (out_valid / out_stall): the verdict of the first failing
// rule and the saturating anomaly total after that item.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); the
// user must keep it written only while the block is idle, as the block does
// not enforce this; unknown indexes are ignored. Results go through the
// second stage and output registers. A new item is taken only when the
// second stage is empty, so per-slot count memory accesses never overlap.
// Slot ids are matched in parallel in flip-flops.
// While out_stall holds a result, one further item is still accepted and
// waits in the second stage; further input is stalled until the result moves.
// Reset clears configuration to defaults, empties the slot table and zeroes
// the anomaly total at once; there is no clearing pass.
module can_frame_anomaly_detector #(
	parameter int TRACKED_SLOTS = cfad_pkg::TRACKED_SLOTS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_write,
	input  logic [cfad_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [cfad_pkg::CFG_DATA_W-1:0]  cfg_data,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             func,
	input  logic [cfad_pkg::ID_BITS-1:0]     can_id,
	input  logic [cfad_pkg::LEN_W-1:0]       length_code,
	input  logic [cfad_pkg::BYTE_W-1:0]      data_byte0,
	input  logic [cfad_pkg::BYTE_W-1:0]      data_byte1,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [2:0]                       verdict,
	output logic [cfad_pkg::TOTAL_W-1:0]     anomaly_total
);

	localparam int IDX_W = (TRACKED_SLOTS > 1) ? $clog2(TRACKED_SLOTS) : 1;

	// configuration registers
	logic [cfad_pkg::KNOWN_W-1:0] known_ids_q;
	logic [cfad_pkg::EXP_W-1:0]   expected_lengths_q;
	logic [cfad_pkg::RPM_W-1:0]   rpm_low_q;
	logic [cfad_pkg::RPM_W-1:0]   rpm_high_q;
	logic [cfad_pkg::BYTE_W-1:0]  temperature_high_q;
	logic [cfad_pkg::BYTE_W-1:0]  fuel_high_q;
	logic [cfad_pkg::COUNT_W-1:0] flood_limit_q;

	// first stage
	logic                 in_accept;
	cfad_pkg::verdict_t   early;
	cfad_pkg::slot_look_t look;
	logic [IDX_W-1:0]     slot_idx;
	logic                 counted;
	logic                 claim;
	logic                 tick;

	// second stage
	logic                         s1_valid_q;
	logic                         func_s1;
	cfad_pkg::verdict_t           early_s1;
	logic                         counted_s1;
	logic                         new_s1;
	logic                         fresh_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic                         s1_done;
	logic [cfad_pkg::COUNT_W-1:0] count_rd;
	logic [cfad_pkg::COUNT_W-1:0] count_old;
	logic [cfad_pkg::COUNT_W-1:0] count_new;
	cfad_pkg::verdict_t           verdict_d;

	// output register
	logic                         out_valid_q;
	cfad_pkg::verdict_t           verdict_q;
	logic [cfad_pkg::TOTAL_W-1:0] total_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_ids_q        <= '0;
			expected_lengths_q <= '0;
			rpm_low_q          <= '0;
			rpm_high_q         <= cfad_pkg::RPM_HIGH_RST;
			temperature_high_q <= cfad_pkg::TEMP_HIGH_RST;
			fuel_high_q        <= cfad_pkg::FUEL_HIGH_RST;
			flood_limit_q      <= cfad_pkg::FLOOD_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cfad_pkg::REG_KNOWN_IDS:        known_ids_q        <= cfg_data;
				cfad_pkg::REG_EXPECTED_LENGTHS: expected_lengths_q <= cfg_data[cfad_pkg::EXP_W-1:0];
				cfad_pkg::REG_RPM_LOW:          rpm_low_q          <= cfg_data[cfad_pkg::RPM_W-1:0];
				cfad_pkg::REG_RPM_HIGH:         rpm_high_q         <= cfg_data[cfad_pkg::RPM_W-1:0];
				cfad_pkg::REG_TEMPERATURE_HIGH: temperature_high_q <= cfg_data[cfad_pkg::BYTE_W-1:0];
				cfad_pkg::REG_FUEL_HIGH:        fuel_high_q        <= cfg_data[cfad_pkg::BYTE_W-1:0];
				cfad_pkg::REG_FLOOD_LIMIT:      flood_limit_q      <= cfg_data[cfad_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// one item in the second stage at a time
	assign in_stall  = s1_valid_q;
	assign in_accept = in_valid && !in_stall;

	// length, id and value rules
	cfad_rules u_rules (
		.known_ids        (known_ids_q),
		.expected_lengths (expected_lengths_q),
		.rpm_low          (rpm_low_q),
		.rpm_high         (rpm_high_q),
		.temperature_high (temperature_high_q),
		.fuel_high        (fuel_high_q),
		.can_id           (can_id),
		.length_code      (length_code),
		.data_byte0       (data_byte0),
		.data_byte1       (data_byte1),
		.early            (early)
	);

	// flood tracking applies only to frames that pass the earlier rules
	assign counted = !func && (early == cfad_pkg::V_OK) && (look.found || look.has_free);
	assign claim   = in_accept && !func && (early == cfad_pkg::V_OK) && !look.found
	                 && look.has_free;
	assign tick    = in_accept && func;

	// tracked id table
	cfad_slots #(
		.TRACKED_SLOTS (TRACKED_SLOTS),
		.IDX_W         (IDX_W)
	) u_slots (
		.clk      (clk),
		.arst_n   (arst_n),
		.can_id   (can_id),
		.claim    (claim),
		.tick     (tick),
		.mark     (s1_done && counted_s1),
		.mark_idx (idx_s1),
		.idx      (slot_idx),
		.look     (look)
	);

	// per-slot frame counts
	cfad_ram #(
		.WIDTH  (cfad_pkg::COUNT_W),
		.DEPTH  (TRACKED_SLOTS),
		.ADDR_W (IDX_W)
	) u_count_ram (
		.clk   (clk),
		.we    (s1_done && counted_s1),
		.waddr (idx_s1),
		.wdata (count_new),
		.re    (in_accept && counted),
		.raddr (slot_idx),
		.rdata (count_rd)
	);

	// stage register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_done) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (in_accept) begin
			func_s1    <= func;
			early_s1   <= early;
			counted_s1 <= counted;
			new_s1     <= !look.found;
			fresh_s1   <= look.fresh;
			idx_s1     <= slot_idx;
		end
	end

	// count update, stale or new slots start from zero
	assign s1_done   = s1_valid_q && (!out_valid_q || !out_stall);
	assign count_old = (new_s1 || !fresh_s1) ? '0 : count_rd;
	assign count_new = (count_old == '1) ? count_old : count_old + 1'b1;

	// final verdict
	always_comb begin
		if (func_s1) begin
			verdict_d = cfad_pkg::V_OK;
		end else if (early_s1 != cfad_pkg::V_OK) begin
			verdict_d = early_s1;
		end else if (counted_s1 && (count_new > flood_limit_q)) begin
			verdict_d = cfad_pkg::V_FLOOD;
		end else begin
			verdict_d = cfad_pkg::V_OK;
		end
	end

	// output register and anomaly total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			total_q     <= '0;
		end else begin
			if (s1_done) begin
				out_valid_q <= 1'b1;
				if ((verdict_d != cfad_pkg::V_OK) && (total_q != '1)) begin
					total_q <= total_q + 1'b1;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_done) begin
			verdict_q <= verdict_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign verdict       = verdict_q;
	assign anomaly_total = total_q;

`ifndef SYNTHESIS
	// an accepted item occupies the second stage next cycle
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid_q)
		else $error("accepted item did not reach second stage");

	// each anomaly bumps the total by exactly one until saturation
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && (verdict_d != cfad_pkg::V_OK) && (total_q != '1))
		|=> (total_q == $past(total_q) + 1'b1))
		else $error("anomaly total did not advance by one");

	// a tick always reports ok
	a_tick_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_done && func_s1) |=> (verdict_q == cfad_pkg::V_OK))
		else $error("tick reported an anomaly");
`endif

endmodule

// ===== rtl/cfad_ram.sv =====
module cfad_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/cfad_rules.sv =====
module cfad_rules (
	input  logic [cfad_pkg::KNOWN_W-1:0] known_ids,
	input  logic [cfad_pkg::EXP_W-1:0]   expected_lengths,
	input  logic [cfad_pkg::RPM_W-1:0]   rpm_low,
	input  logic [cfad_pkg::RPM_W-1:0]   rpm_high,
	input  logic [cfad_pkg::BYTE_W-1:0]  temperature_high,
	input  logic [cfad_pkg::BYTE_W-1:0]  fuel_high,
	input  logic [cfad_pkg::ID_BITS-1:0] can_id,
	input  logic [cfad_pkg::LEN_W-1:0]   length_code,
	input  logic [cfad_pkg::BYTE_W-1:0]  data_byte0,
	input  logic [cfad_pkg::BYTE_W-1:0]  data_byte1,
	output cfad_pkg::verdict_t           early
);

	logic [cfad_pkg::KNOWN_COUNT-1:0] id_match;
	logic [2:0]                       len_match;
	logic [cfad_pkg::RPM_W-1:0]       rpm;
	logic                             len_bad;
	logic                             rpm_bad;
	logic                             temp_bad;
	logic                             fuel_bad;

	// compare against each known id
	always_comb begin
		for (int k = 0; k < cfad_pkg::KNOWN_COUNT; k++) begin
			id_match[k] = (known_ids[k*cfad_pkg::ID_BITS +: cfad_pkg::ID_BITS] == can_id);
		end
		for (int k = 0; k < 3; k++) begin
			len_match[k] = (expected_lengths[k*cfad_pkg::LEN_W +: cfad_pkg::LEN_W] == length_code);
		end
	end

	// value range checks
	assign rpm      = {data_byte0, data_byte1};
	assign len_bad  = (length_code > cfad_pkg::LEN_W'(cfad_pkg::MAX_LENGTH_CODE));
	assign rpm_bad  = id_match[0] && len_match[0] && ((rpm < rpm_low) || (rpm > rpm_high));
	assign temp_bad = id_match[1] && len_match[1] && (data_byte0 > temperature_high);
	assign fuel_bad = id_match[2] && len_match[2] && (data_byte0 > fuel_high);

	// first failing rule wins
	always_comb begin
		if (len_bad) begin
			early = cfad_pkg::V_LENGTH;
		end else if (!(|id_match)) begin
			early = cfad_pkg::V_UNKNOWN;
		end else if (rpm_bad || temp_bad || fuel_bad) begin
			early = cfad_pkg::V_RANGE;
		end else begin
			early = cfad_pkg::V_OK;
		end
	end

endmodule

// ===== rtl/cfad_slots.sv =====
module cfad_slots #(
	parameter int TRACKED_SLOTS = cfad_pkg::TRACKED_SLOTS_DEF,
	parameter int IDX_W         = (TRACKED_SLOTS > 1) ? $clog2(TRACKED_SLOTS) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [cfad_pkg::ID_BITS-1:0] can_id,
	input  logic                         claim,
	input  logic                         tick,
	input  logic                         mark,
	input  logic [IDX_W-1:0]             mark_idx,
	output logic [IDX_W-1:0]             idx,
	output cfad_pkg::slot_look_t         look
);

	logic [TRACKED_SLOTS-1:0]     valid_q;
	logic [TRACKED_SLOTS-1:0]     fresh_q;
	logic [cfad_pkg::ID_BITS-1:0] id_q [TRACKED_SLOTS];
	logic [TRACKED_SLOTS-1:0]     match;
	logic [IDX_W-1:0]             hit_idx;
	logic [IDX_W-1:0]             free_idx;
	logic                         any_hit;
	logic                         any_free;

	// parallel id match and lowest-slot priority
	always_comb begin
		hit_idx  = '0;
		free_idx = '0;
		any_hit  = 1'b0;
		any_free = 1'b0;
		for (int k = TRACKED_SLOTS - 1; k >= 0; k--) begin
			match[k] = valid_q[k] && (id_q[k] == can_id);
			if (match[k]) begin
				any_hit = 1'b1;
				hit_idx = IDX_W'(k);
			end
			if (!valid_q[k]) begin
				any_free = 1'b1;
				free_idx = IDX_W'(k);
			end
		end
	end

	assign idx           = any_hit ? hit_idx : free_idx;
	assign look.found    = any_hit;
	assign look.has_free = any_free;
	assign look.fresh    = fresh_q[idx];

	// valid and fresh bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fresh_q <= '0;
		end else begin
			if (claim) begin
				valid_q[free_idx] <= 1'b1;
			end
			if (tick) begin
				fresh_q <= '0;
			end
			if (mark) begin
				fresh_q[mark_idx] <= 1'b1;
			end
		end
	end

	// slot ids
	always_ff @(posedge clk) begin
		if (claim) begin
			id_q[free_idx] <= can_id;
		end
	end

endmodule
